@@ hdl/ith_pkg.sv @@
// Package for the ISODATA threshold binarizer: widths, action codes and the
// request type passed from the front queue to the back engine. No dependencies.
package ith_pkg;

    localparam int COUNT_BITS = 20;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_ROUNDS = 32;

    localparam int PIX_W     = 8;
    localparam int NUM_BINS  = 1 << PIX_W;
    localparam int THR_W     = PIX_W + FRAC_BITS;
    localparam int CNT_SUM_W = COUNT_BITS + PIX_W;
    localparam int SUM_W     = COUNT_BITS + 2 * PIX_W;
    localparam int IDX_W     = PIX_W + 1;
    localparam int DCNT_W    = $clog2(THR_W + 1);
    localparam int ROUND_W   = $clog2(MAX_ROUNDS + 1);
    localparam int ACC_END   = NUM_BINS + 2;

    localparam logic [COUNT_BITS-1:0] BIN_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [THR_W-1:0]      HALF_STEP = THR_W'(1) << (FRAC_BITS - 1);

    typedef logic [1:0] t_action;
    localparam t_action ACT_LOAD     = 2'd0;
    localparam t_action ACT_LAST     = 2'd1;
    localparam t_action ACT_CLASSIFY = 2'd2;
    localparam t_action ACT_SPARE    = 2'd3;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef struct packed {
        t_action             action;
        logic [PIX_W-1:0]    pixel;
    } t_item;

endpackage

@@ hdl/ith_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ith_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/ith_front.sv @@
// Front part: accepts requests, drops the spare action code and holds the rest
// in a two-entry queue for the back engine. Depends on ith_pkg.
module ith_front
    import ith_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_action          i_action,
    input  logic [PIX_W-1:0] i_pixel_value,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  logic             i_q_pop
);

    t_item      r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       accept;

    // classify the request: the spare code is taken and dropped
    always_comb begin
        o_stall   = (r_cnt == 2'd2);
        accept    = i_valid && !o_stall;
        push      = accept && (i_action != ACT_SPARE);
        o_q_valid = (r_cnt != 2'd0);
        o_q_item  = r_slot[r_rd];
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_q_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= '{action: i_action, pixel: i_pixel_value};
        end
    end

`ifndef SYNTHESIS
    a_spare_not_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_SPARE) |=> (r_cnt <= $past(r_cnt)))
        else $error("spare action entered the queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty queue");
`endif

endmodule

@@ hdl/ith_back.sv @@
// Back part: histogram update, threshold search (min/max scan, class sums,
// shared restoring divider) and result register. Depends on ith_pkg, ith_ram.
module ith_back
    import ith_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    input  logic             i_cfg_valid,
    input  logic [PIX_W-1:0] i_cfg_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_result_kind,
    output logic [PIX_W-1:0] o_threshold_whole,
    output logic             o_flat_image,
    output logic [PIX_W-1:0] o_binary_value
);

    typedef enum logic [3:0] {
        S_IDLE, S_RMW, S_SCAN, S_MM, S_ACC, S_DINIT, S_DRUN, S_UPD, S_REPORT
    } t_state;

    t_state                r_state;
    logic [PIX_W-1:0]      r_fg;
    logic [PIX_W-1:0]      r_pix;
    logic                  r_last;
    logic [THR_W-1:0]      r_thr;
    logic                  r_flat;
    logic [NUM_BINS-1:0]   r_bin_vld;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_any;
    logic [PIX_W-1:0]      r_lo;
    logic [PIX_W-1:0]      r_hi;
    logic                  r_s1_live;
    logic [PIX_W-1:0]      r_s1_idx;
    logic                  r_s2_live;
    logic                  r_s2_below;
    logic [CNT_SUM_W-1:0]  r_s2_cnt;
    logic [SUM_W-1:0]      r_s2_prod;
    logic [CNT_SUM_W-1:0]  r_cnt_lo;
    logic [CNT_SUM_W-1:0]  r_cnt_hi;
    logic [SUM_W-1:0]      r_sum_lo;
    logic [SUM_W-1:0]      r_sum_hi;
    logic                  r_sel;
    logic [CNT_SUM_W-1:0]  r_den;
    logic [CNT_SUM_W-1:0]  r_rem;
    logic [THR_W-1:0]      r_bits;
    logic [THR_W-1:0]      r_quo;
    logic [DCNT_W-1:0]     r_dcnt;
    logic [THR_W-1:0]      r_mlo;
    logic [THR_W-1:0]      r_mhi;
    logic [ROUND_W-1:0]    r_round;
    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [PIX_W-1:0]      r_out_whole;
    logic                  r_out_flat;
    logic [PIX_W-1:0]      r_out_bin;

    logic                  out_free;
    logic                  pop;
    logic                  ram_we;
    logic [PIX_W-1:0]      ram_raddr;
    logic [COUNT_BITS-1:0] ram_q;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] c_s1;
    logic [CNT_SUM_W-1:0]  den_sel;
    logic [SUM_W-1:0]      num_sel;
    logic [CNT_SUM_W:0]    trial;
    logic                  ge;
    logic [CNT_SUM_W:0]    trial_sub;
    logic [THR_W-1:0]      quo_next;
    logic [THR_W:0]        mean_sum;
    logic [THR_W-1:0]      next_t;
    logic [THR_W-1:0]      delta;
    logic [PIX_W:0]        mid;
    logic [THR_W-1:0]      t_start;
    logic                  above;

    ith_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pix),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // datapath decode
    always_comb begin
        out_free  = !r_out_valid || !i_stall;
        pop       = (r_state == S_IDLE) && i_q_valid &&
                    ((i_q_item.action != ACT_CLASSIFY) || out_free);
        ram_raddr = (r_state == S_ACC) ? r_idx[PIX_W-1:0] : i_q_item.pixel;
        ram_we    = (r_state == S_RMW);
        if (!r_bin_vld[r_pix]) begin
            ram_wdata = COUNT_BITS'(1);
        end else if (ram_q == BIN_MAX) begin
            ram_wdata = ram_q;
        end else begin
            ram_wdata = ram_q + COUNT_BITS'(1);
        end
        c_s1      = r_bin_vld[r_s1_idx] ? ram_q : '0;
        den_sel   = r_sel ? r_cnt_hi : r_cnt_lo;
        num_sel   = r_sel ? r_sum_hi : r_sum_lo;
        trial     = {r_rem, r_bits[THR_W-1]};
        ge        = (trial >= {1'b0, r_den});
        trial_sub = trial - {1'b0, r_den};
        quo_next  = {r_quo[THR_W-2:0], ge};
        mean_sum  = {1'b0, r_mlo} + {1'b0, r_mhi};
        next_t    = mean_sum[THR_W:1];
        delta     = (next_t > r_thr) ? (next_t - r_thr) : (r_thr - next_t);
        mid       = {1'b0, r_lo} + {1'b0, r_hi};
        t_start   = THR_W'({mid, {FRAC_BITS{1'b0}}} >> 1);
        above     = ({i_q_item.pixel, {FRAC_BITS{1'b0}}} > r_thr);
        o_q_pop   = pop;
    end

    // histogram occupancy bits: an unset bin reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_vld <= '0;
        end else if (r_state == S_REPORT && out_free) begin
            r_bin_vld <= '0;
        end else if (ram_we) begin
            r_bin_vld[r_pix] <= 1'b1;
        end
    end

    // sequencer, search datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fg        <= '1;
            r_thr       <= '0;
            r_flat      <= 1'b0;
            r_out_valid <= 1'b0;
            r_s1_live   <= 1'b0;
            r_s2_live   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fg <= i_cfg_data;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_pix  <= i_q_item.pixel;
                        r_last <= (i_q_item.action == ACT_LAST);
                        if (i_q_item.action == ACT_CLASSIFY) begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= KIND_PIXEL;
                            r_out_whole <= r_thr[THR_W-1:FRAC_BITS];
                            r_out_flat  <= r_flat;
                            r_out_bin   <= (!r_flat && above) ? r_fg : '0;
                        end else begin
                            r_state <= S_RMW;
                        end
                    end
                end
                S_RMW: begin
                    r_idx <= '0;
                    r_any <= 1'b0;
                    r_state <= r_last ? S_SCAN : S_IDLE;
                end
                S_SCAN: begin
                    if (r_bin_vld[r_idx[PIX_W-1:0]]) begin
                        if (!r_any) begin
                            r_lo <= r_idx[PIX_W-1:0];
                        end
                        r_hi  <= r_idx[PIX_W-1:0];
                        r_any <= 1'b1;
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(NUM_BINS - 1)) begin
                        r_state <= S_MM;
                    end
                end
                S_MM: begin
                    if (!r_any || r_lo == r_hi) begin
                        r_thr   <= r_any ? {r_lo, {FRAC_BITS{1'b0}}} : '0;
                        r_flat  <= 1'b1;
                        r_state <= S_REPORT;
                    end else begin
                        r_thr     <= t_start;
                        r_flat    <= 1'b0;
                        r_round   <= '0;
                        r_idx     <= '0;
                        r_cnt_lo  <= '0;
                        r_cnt_hi  <= '0;
                        r_sum_lo  <= '0;
                        r_sum_hi  <= '0;
                        r_s1_live <= 1'b0;
                        r_s2_live <= 1'b0;
                        r_state   <= S_ACC;
                    end
                end
                S_ACC: begin
                    // read, weigh by bin value, then accumulate per class
                    r_idx      <= r_idx + IDX_W'(1);
                    r_s1_live  <= (r_idx < IDX_W'(NUM_BINS));
                    r_s1_idx   <= r_idx[PIX_W-1:0];
                    r_s2_live  <= r_s1_live;
                    r_s2_cnt   <= CNT_SUM_W'(c_s1);
                    r_s2_prod  <= SUM_W'(c_s1 * r_s1_idx);
                    r_s2_below <= ({r_s1_idx, {FRAC_BITS{1'b0}}} < r_thr);
                    if (r_s2_live) begin
                        if (r_s2_below) begin
                            r_cnt_lo <= r_cnt_lo + r_s2_cnt;
                            r_sum_lo <= r_sum_lo + r_s2_prod;
                        end else begin
                            r_cnt_hi <= r_cnt_hi + r_s2_cnt;
                            r_sum_hi <= r_sum_hi + r_s2_prod;
                        end
                    end
                    if (r_idx == IDX_W'(ACC_END)) begin
                        r_sel   <= 1'b0;
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    if (den_sel == '0) begin
                        if (r_sel) begin
                            r_mhi   <= '0;
                            r_state <= S_UPD;
                        end else begin
                            r_mlo <= '0;
                            r_sel <= 1'b1;
                        end
                    end else begin
                        r_den   <= den_sel;
                        r_rem   <= num_sel[SUM_W-1:PIX_W];
                        r_bits  <= {num_sel[PIX_W-1:0], {FRAC_BITS{1'b0}}};
                        r_quo   <= '0;
                        r_dcnt  <= DCNT_W'(THR_W);
                        r_state <= S_DRUN;
                    end
                end
                S_DRUN: begin
                    // one quotient bit per cycle
                    r_rem  <= ge ? trial_sub[CNT_SUM_W-1:0] : trial[CNT_SUM_W-1:0];
                    r_bits <= r_bits << 1;
                    r_quo  <= quo_next;
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        if (r_sel) begin
                            r_mhi   <= quo_next;
                            r_state <= S_UPD;
                        end else begin
                            r_mlo   <= quo_next;
                            r_sel   <= 1'b1;
                            r_state <= S_DINIT;
                        end
                    end
                end
                S_UPD: begin
                    r_thr <= next_t;
                    if (delta < HALF_STEP || r_round == ROUND_W'(MAX_ROUNDS - 1)) begin
                        r_state <= S_REPORT;
                    end else begin
                        r_round   <= r_round + ROUND_W'(1);
                        r_idx     <= '0;
                        r_cnt_lo  <= '0;
                        r_cnt_hi  <= '0;
                        r_sum_lo  <= '0;
                        r_sum_hi  <= '0;
                        r_s1_live <= 1'b0;
                        r_s2_live <= 1'b0;
                        r_state   <= S_ACC;
                    end
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_REPORT;
                        r_out_whole <= r_thr[THR_W-1:FRAC_BITS];
                        r_out_flat  <= r_flat;
                        r_out_bin   <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_threshold_whole = r_out_whole;
    assign o_flat_image      = r_out_flat;
    assign o_binary_value    = r_out_bin;

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRUN) |-> (r_rem < r_den))
        else $error("divider remainder out of range");
    a_flat_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flat |-> (r_thr[FRAC_BITS-1:0] == '0))
        else $error("flat threshold has fraction bits");
    a_classify_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_q_item.action == ACT_CLASSIFY) |=> r_out_valid)
        else $error("classify request produced no result");
`endif

endmodule

@@ hdl/isodata_threshold_binarizer.sv @@
// Top level of the ISODATA threshold binarizer: front queue plus back engine.
// Depends on ith_pkg, ith_front, ith_back (and ith_ram through ith_back).
//
//   channel   handshake                  payload
//   input     i_valid / o_stall          i_action, i_pixel_value
//   output    o_valid / i_stall          o_result_kind, o_threshold_whole,
//                                        o_flat_image, o_binary_value
//   config    i_cfg_valid / o_cfg_ready  i_cfg_data (foreground value)
//
// Load request: histogram RAM read, then write, in the back engine. Classify
// request: handled in the idle state. Last-pixel request: the load's read and
// write, a min/max scan, then per search round the class sums over the RAM,
// up to two divisions on the shared divider and an update, up to 32 rounds,
// then a report.
// Reset is synchronous, active low; it empties the histogram via occupancy bits.
// A two-entry queue lets input requests land while the result register stalls.
module isodata_threshold_binarizer
    import ith_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_action,
    input  logic [PIX_W-1:0] i_pixel_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_result_kind,
    output logic [PIX_W-1:0] o_threshold_whole,
    output logic             o_flat_image,
    output logic [PIX_W-1:0] o_binary_value,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PIX_W-1:0] i_cfg_data
);

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // always take register writes
    assign o_cfg_ready = 1'b1;

    ith_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_pixel_value (i_pixel_value),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    ith_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_kind     (o_result_kind),
        .o_threshold_whole (o_threshold_whole),
        .o_flat_image      (o_flat_image),
        .o_binary_value    (o_binary_value)
    );

endmodule

@@ tb/sv/isodata_threshold_binarizer_test.sv @@
// Self-checking testbench for isodata_threshold_binarizer: a directed table,
// then random images, checked against an in-bench threshold predictor.
// Depends on ith_pkg and the isodata_threshold_binarizer RTL.
`timescale 1ns / 100ps

module isodata_threshold_binarizer_test;
    import ith_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 40;

    typedef struct {
        logic             kind;
        logic [PIX_W-1:0] thr;
        logic             flat;
        logic [PIX_W-1:0] bin;
    } t_outcome;

    typedef struct {
        t_action          act;
        logic [PIX_W-1:0] pix;
        bit               typed;
        t_outcome         res;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [1:0]       i_action = ACT_LOAD;
    logic [PIX_W-1:0] i_pixel_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic             o_result_kind;
    logic [PIX_W-1:0] o_threshold_whole;
    logic             o_flat_image;
    logic [PIX_W-1:0] o_binary_value;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [PIX_W-1:0] i_cfg_data = '0;

    // Predictor state
    logic [COUNT_BITS-1:0] hist [NUM_BINS];
    logic [THR_W-1:0]      thr_fixed;
    logic                  flat_seen;
    logic [PIX_W-1:0]      fg_value;

    t_outcome pending [$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       quiet = 1'b0;
    bit       hold_req = 1'b0;

    isodata_threshold_binarizer uut (.*);

    always #1 i_clk = ~i_clk;

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // floor(num * 2^FRAC_BITS / den)
    function automatic longint unsigned fixed_div(longint unsigned num,
                                                  longint unsigned den);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic void search_threshold();
        int lo, hi;
        longint unsigned t, slo, clo, shi, chi, mlo, mhi, nxt, dif;
        lo = -1;
        hi = -1;
        for (int v = 0; v < NUM_BINS; v++) begin
            if (hist[v] != 0) begin
                if (lo < 0) lo = v;
                hi = v;
            end
        end
        if (lo < 0 || lo == hi) begin
            thr_fixed = THR_W'((lo < 0 ? 0 : lo)) << FRAC_BITS;
            flat_seen = 1'b1;
            return;
        end
        flat_seen = 1'b0;
        t = (longint'(lo + hi) << FRAC_BITS) >> 1;
        for (int rnd = 0; rnd < MAX_ROUNDS; rnd++) begin
            slo = 0; clo = 0; shi = 0; chi = 0;
            for (int v = 0; v < NUM_BINS; v++) begin
                if ((longint'(v) << FRAC_BITS) < t) begin
                    slo += hist[v] * v;
                    clo += hist[v];
                end else begin
                    shi += hist[v] * v;
                    chi += hist[v];
                end
            end
            mlo = clo != 0 ? fixed_div(slo, clo) : 0;
            mhi = chi != 0 ? fixed_div(shi, chi) : 0;
            nxt = (mlo + mhi) >> 1;
            dif = nxt > t ? nxt - t : t - nxt;
            t = nxt;
            if (dif < HALF_STEP) break;
        end
        thr_fixed = t[THR_W-1:0];
    endfunction

    function automatic void count_pixel(logic [PIX_W-1:0] p);
        if (hist[p] != BIN_MAX) hist[p] = hist[p] + 1'b1;
    endfunction

    // Advance the predictor by one accepted request; returns 1 with a result
    function automatic bit predict_request(t_action a, logic [PIX_W-1:0] p,
                                           output t_outcome o);
        o = '{KIND_PIXEL, '0, 1'b0, '0};
        case (a)
            ACT_LOAD: begin
                count_pixel(p);
                return 1'b0;
            end
            ACT_LAST: begin
                count_pixel(p);
                search_threshold();
                foreach (hist[v]) hist[v] = '0;
                o = '{KIND_REPORT, thr_fixed[THR_W-1 -: PIX_W], flat_seen, '0};
                return 1'b1;
            end
            ACT_CLASSIFY: begin
                o.kind = KIND_PIXEL;
                o.thr  = thr_fixed[THR_W-1 -: PIX_W];
                o.flat = flat_seen;
                o.bin  = (!flat_seen && ({p, {FRAC_BITS{1'b0}}} > thr_fixed))
                         ? fg_value : '0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offer one request and wait for acceptance
    task automatic send_request(t_action a, logic [PIX_W-1:0] p, bit typed,
                                t_outcome fixed_res);
        t_outcome o;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= a;
        i_pixel_value <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (predict_request(a, p, o)) pending.push_back(typed ? fixed_res : o);
    endtask

    // Drain results and let trailing loads finish before a register write
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_fg(logic [PIX_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        fg_value = v;
    endtask

    // One random image: loads, the last pixel, then some classify requests
    task automatic random_image();
        int n, shape;
        logic [PIX_W-1:0] a, b, p;
        t_outcome none;
        none  = '{KIND_PIXEL, '0, 1'b0, '0};
        n     = $urandom_range(0, 22);
        shape = $urandom_range(0, 9);
        a     = PIX_W'($urandom);
        b     = PIX_W'($urandom);
        for (int i = 0; i <= n; i++) begin
            if (shape == 0) p = a;
            else if (shape < 6)
                p = ($urandom_range(0, 1) ? a : b) ^ PIX_W'($urandom_range(0, 7));
            else p = PIX_W'($urandom);
            if ($urandom_range(0, 29) == 0)
                send_request(ACT_SPARE, PIX_W'($urandom), 1'b0, none);
            send_request(i == n ? ACT_LAST : ACT_LOAD, p, 1'b0, none);
        end
        repeat ($urandom_range(0, 8))
            send_request(ACT_CLASSIFY, PIX_W'($urandom), 1'b0, none);
    endtask

    // Receiver: check results, stall in bursts, honor a long hold-off
    initial begin
        int burst, hold;
        t_outcome e;
        burst = 0;
        hold  = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall && i_rst_n) begin
                if (pending.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
                end else begin
                    e = pending.pop_front();
                    if (o_result_kind !== e.kind || o_threshold_whole !== e.thr ||
                        o_flat_image !== e.flat || o_binary_value !== e.bin) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch kind/thr/flat/bin exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     e.kind, e.thr, e.flat, e.bin, o_result_kind,
                                     o_threshold_whole, o_flat_image, o_binary_value);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = 300;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus
    initial begin
        t_dir_row rows [21];
        t_outcome none;
        none = '{KIND_PIXEL, '0, 1'b0, '0};
        rows = '{
            // classify before any compute: threshold 0, not flat
            '{ACT_CLASSIFY, 8'd0,   1'b1, '{KIND_PIXEL, 8'd0, 1'b0, 8'd0}},
            '{ACT_CLASSIFY, 8'd255, 1'b1, '{KIND_PIXEL, 8'd0, 1'b0, 8'd255}},
            '{ACT_CLASSIFY, 8'd1,   1'b1, '{KIND_PIXEL, 8'd0, 1'b0, 8'd255}},
            '{ACT_SPARE,    8'd9,   1'b0, none},
            // flat image
            '{ACT_LOAD,     8'd7,   1'b0, none},
            '{ACT_LAST,     8'd7,   1'b1, '{KIND_REPORT, 8'd7, 1'b1, 8'd0}},
            '{ACT_CLASSIFY, 8'd255, 1'b1, '{KIND_PIXEL, 8'd7, 1'b1, 8'd0}},
            // extremes only: threshold 127.5
            '{ACT_LOAD,     8'd0,   1'b0, none},
            '{ACT_LAST,     8'd255, 1'b1, '{KIND_REPORT, 8'd127, 1'b0, 8'd0}},
            '{ACT_CLASSIFY, 8'd128, 1'b1, '{KIND_PIXEL, 8'd127, 1'b0, 8'd255}},
            '{ACT_CLASSIFY, 8'd127, 1'b1, '{KIND_PIXEL, 8'd127, 1'b0, 8'd0}},
            // skewed image, predicted
            '{ACT_LOAD,     8'd0,   1'b0, none},
            '{ACT_LOAD,     8'd0,   1'b0, none},
            '{ACT_LOAD,     8'd10,  1'b0, none},
            '{ACT_LOAD,     8'd200, 1'b0, none},
            '{ACT_LAST,     8'd255, 1'b0, none},
            '{ACT_CLASSIFY, 8'd100, 1'b0, none},
            '{ACT_CLASSIFY, 8'd201, 1'b0, none},
            // single-pixel image is flat at zero
            '{ACT_LAST,     8'd0,   1'b1, '{KIND_REPORT, 8'd0, 1'b1, 8'd0}},
            '{ACT_CLASSIFY, 8'd170, 1'b1, '{KIND_PIXEL, 8'd0, 1'b1, 8'd0}},
            '{ACT_SPARE,    8'd255, 1'b0, none}
        };
        foreach (hist[v]) hist[v] = '0;
        thr_fixed = '0;
        flat_seen = 1'b0;
        fg_value  = 8'd255;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_fg(8'd255);
        foreach (rows[i]) send_request(rows[i].act, rows[i].pix, rows[i].typed, rows[i].res);

        // Random phases under several foreground settings
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: write_fg(8'd0);
                1: write_fg(8'd255);
                default: write_fg(PIX_W'($urandom));
            endcase
            if (ph == 5) quiet = 1'b1;
            if (ph == 2) begin
                hold_req = 1'b1;
                repeat (40) send_request(ACT_CLASSIFY, PIX_W'($urandom), 1'b0, none);
            end
            repeat (4) random_image();
        end

        wait_idle();
        if (mismatches == 0 && pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ith_pkg.sv
hdl/ith_ram.sv
hdl/ith_front.sv
hdl/ith_back.sv
hdl/isodata_threshold_binarizer.sv
tb/sv/isodata_threshold_binarizer_test.sv
